FILE: sv/qte_pkg.sv
// ============================================================================
// qte_pkg
// Shared constants for the quaternion to roll, pitch and yaw converter:
// default widths, CORDIC step count, prescale and the arctangent table.
// ============================================================================
package qte_pkg;

    localparam int QUAT_WIDTH_DEF  = 16;
    localparam int ANGLE_WIDTH_DEF = 16;

    // cordic vectoring steps and prescale of the coordinates
    localparam int CORDIC_STEPS   = 31;
    localparam int PRESCALE_BITS  = 24;
    localparam int ZW             = 33;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ARC_TABLE [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
        32'd10, 32'd5, 32'd3, 32'd1, 32'd1
    };

endpackage

FILE: sv/quaternion_to_euler.sv
// ============================================================================
// quaternion_to_euler
// Converts a fixed-point orientation quaternion to roll, pitch and yaw as
// signed binary angles through product sums, a square root and three CORDIC
// vectoring lanes.
// ============================================================================
// One beat enters per cycle and one result leaves per cycle while no
// result waits on angle_stall. The stages are the input register, the
// products, the saturated sine and cosine terms, the squared pitch sine,
// the square root setup, QUAT_WIDTH-1 square root steps for the pitch
// cosine, the quadrant fold, 31 CORDIC steps and the output register.
// The pipeline moves as one: while a result waits on angle_stall, every
// stage holds and quat_stall is raised.
module quaternion_to_euler #(
    parameter int QUAT_WIDTH  = qte_pkg::QUAT_WIDTH_DEF,
    parameter int ANGLE_WIDTH = qte_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          quat_valid,
    output logic                          quat_stall,
    input  logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  quat_z,
    output logic                          angle_valid,
    input  logic                          angle_stall,
    output logic signed [ANGLE_WIDTH-1:0] roll_angle,
    output logic signed [ANGLE_WIDTH-1:0] pitch_angle,
    output logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    output logic                          pitch_clamped
);

    localparam int FRAC  = QUAT_WIDTH - 2;
    localparam int PW    = 2 * QUAT_WIDTH;
    localparam int DW    = PW + 2;
    localparam int SQ    = QUAT_WIDTH - 1;
    localparam int NW    = 2 * FRAC + 2;
    localparam int LW    = QUAT_WIDTH + 1;
    localparam int CW    = QUAT_WIDTH + qte_pkg::PRESCALE_BITS + 4;
    localparam int ZW    = qte_pkg::ZW;
    localparam int NSTEP = qte_pkg::CORDIC_STEPS;
    localparam int SH    = 32 - ANGLE_WIDTH;

    localparam logic signed [DW-1:0] QMAX  = DW'((64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1);
    localparam logic signed [DW-1:0] QMIN  = DW'(-(64'sd1 <<< (QUAT_WIDTH - 1)));
    localparam logic signed [DW-1:0] ONE_D = DW'(64'sd1 <<< FRAC);
    localparam logic signed [DW-1:0] RND   = DW'(64'sd1 <<< (FRAC - 3));
    localparam logic signed [QUAT_WIDTH-1:0] ONE_Q = QUAT_WIDTH'(64'sd1 <<< FRAC);
    localparam logic [NW-1:0] ONE_SQ = NW'(64'd1 << (2 * FRAC));
    localparam logic signed [ZW-1:0] PI_Z = ZW'(64'sd1 <<< 31);
    localparam logic signed [ANGLE_WIDTH-1:0] QUARTER =
        ANGLE_WIDTH'(64'sd1 <<< (ANGLE_WIDTH - 2));

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] sinr;
        logic signed [QUAT_WIDTH-1:0] cosr;
        logic signed [QUAT_WIDTH-1:0] sinp;
        logic signed [QUAT_WIDTH-1:0] siny;
        logic signed [QUAT_WIDTH-1:0] cosy;
        logic                         clamp;
    } side_t;

    function automatic logic signed [QUAT_WIDTH-1:0] sat_q(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        r = v;
        if (v > QMAX)
            r = QMAX;
        else if (v < QMIN)
            r = QMIN;
        return r[QUAT_WIDTH-1:0];
    endfunction

    function automatic logic signed [DW-1:0] dsum(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [DW-1:0] s;
        s = (a >>> 1) + (b >>> 1) + RND;
        return s >>> (FRAC - 2);
    endfunction

    // global advance: the whole pipe holds while the output beat waits
    logic adv;
    logic out_valid_reg;
    assign adv         = !(out_valid_reg && angle_stall);
    assign quat_stall  = !adv;
    assign angle_valid = out_valid_reg;

    // input register
    logic                         va_reg;
    logic signed [QUAT_WIDTH-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (adv)
            va_reg <= quat_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv && quat_valid)
        begin
            qw_reg <= quat_w;
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
        end
    end

    // products
    logic                 vb_reg;
    logic signed [PW-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [PW-1:0] p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (adv)
            vb_reg <= va_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_wx_reg <= qw_reg * qx_reg;
            p_yz_reg <= qy_reg * qz_reg;
            p_xx_reg <= qx_reg * qx_reg;
            p_yy_reg <= qy_reg * qy_reg;
            p_wy_reg <= qw_reg * qy_reg;
            p_zx_reg <= qz_reg * qx_reg;
            p_wz_reg <= qw_reg * qz_reg;
            p_xy_reg <= qx_reg * qy_reg;
            p_zz_reg <= qz_reg * qz_reg;
        end
    end

    // doubled sums and saturated sine and cosine terms
    logic  vc_reg;
    side_t tc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (adv)
            vc_reg <= vb_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tc_reg.sinr  <= sat_q(dsum(DW'(p_wx_reg), DW'(p_yz_reg)));
            tc_reg.cosr  <= sat_q(ONE_D - dsum(DW'(p_xx_reg), DW'(p_yy_reg)));
            tc_reg.sinp  <= sat_q(dsum(DW'(p_wy_reg), -DW'(p_zx_reg)));
            tc_reg.siny  <= sat_q(dsum(DW'(p_wz_reg), DW'(p_xy_reg)));
            tc_reg.cosy  <= sat_q(ONE_D - dsum(DW'(p_yy_reg), DW'(p_zz_reg)));
            tc_reg.clamp <= 1'b0;
        end
    end

    // pitch sine squared and saturation flag
    logic                 vd_reg;
    side_t                td_reg;
    logic signed [PW-1:0] sq_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (adv)
            vd_reg <= vc_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= tc_reg.sinp * tc_reg.sinp;
            td_reg <= '{sinr: tc_reg.sinr, cosr: tc_reg.cosr, sinp: tc_reg.sinp,
                        siny: tc_reg.siny, cosy: tc_reg.cosy,
                        clamp: (tc_reg.sinp >= ONE_Q) || (tc_reg.sinp <= -ONE_Q)};
        end
    end

    // square root, one result bit per stage
    logic          vs_reg [0:SQ];
    side_t         ts_reg [0:SQ];
    logic [NW-1:0] sn_reg [0:SQ];
    logic [NW-1:0] sr_reg [0:SQ];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vs_reg[0] <= 1'b0;
        else if (adv)
            vs_reg[0] <= vd_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn_reg[0] <= ONE_SQ - sq_reg[NW-1:0];
            sr_reg[0] <= '0;
            ts_reg[0] <= td_reg;
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        localparam logic [NW-1:0] BIT = NW'(64'd1 << (2 * (SQ - 1 - k)));
        logic [NW-1:0] trial;
        assign trial = sr_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vs_reg[k+1] <= 1'b0;
            else if (adv)
                vs_reg[k+1] <= vs_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ts_reg[k+1] <= ts_reg[k];
                if (sn_reg[k] >= trial)
                begin
                    sn_reg[k+1] <= sn_reg[k] - trial;
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + BIT;
                end
                else
                begin
                    sn_reg[k+1] <= sn_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
            end
        end
    end

    // lane inputs: roll, pitch, yaw
    logic signed [LW-1:0] ly [0:2];
    logic signed [LW-1:0] lx [0:2];
    always_comb
    begin
        ly[0] = LW'(ts_reg[SQ].sinr);
        lx[0] = LW'(ts_reg[SQ].cosr);
        ly[1] = LW'(ts_reg[SQ].sinp);
        lx[1] = LW'({1'b0, sr_reg[SQ][FRAC:0]});
        ly[2] = LW'(ts_reg[SQ].siny);
        lx[2] = LW'(ts_reg[SQ].cosy);
    end

    // cordic lanes
    logic                 cv_reg [0:NSTEP];
    logic                 cc_reg [0:NSTEP];
    logic                 cn_reg [0:NSTEP];
    logic signed [CW-1:0] cx_reg [0:NSTEP][0:2];
    logic signed [CW-1:0] cy_reg [0:NSTEP][0:2];
    logic signed [ZW-1:0] cz_reg [0:NSTEP][0:2];

    // quadrant fold and prescale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (adv)
            cv_reg[0] <= vs_reg[SQ];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cc_reg[0] <= ts_reg[SQ].clamp;
            cn_reg[0] <= ts_reg[SQ].sinp[QUAT_WIDTH-1];
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_fold
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (lx[l] < 0)
                begin
                    cx_reg[0][l] <= (-CW'(lx[l])) <<< qte_pkg::PRESCALE_BITS;
                    cy_reg[0][l] <= (-CW'(ly[l])) <<< qte_pkg::PRESCALE_BITS;
                    cz_reg[0][l] <= (ly[l] >= 0) ? PI_Z : -PI_Z;
                end
                else
                begin
                    cx_reg[0][l] <= CW'(lx[l]) <<< qte_pkg::PRESCALE_BITS;
                    cy_reg[0][l] <= CW'(ly[l]) <<< qte_pkg::PRESCALE_BITS;
                    cz_reg[0][l] <= '0;
                end
            end
        end
    end

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_cordic
        localparam logic signed [ZW-1:0] ARC = ZW'(qte_pkg::ARC_TABLE[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else if (adv)
                cv_reg[i+1] <= cv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cc_reg[i+1] <= cc_reg[i];
                cn_reg[i+1] <= cn_reg[i];
            end
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic signed [CW-1:0] xs, ys;
            assign xs = cx_reg[i][l] >>> i;
            assign ys = cy_reg[i][l] >>> i;

            // rotate toward the x axis
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (cy_reg[i][l] > 0)
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] + ys;
                        cy_reg[i+1][l] <= cy_reg[i][l] - xs;
                        cz_reg[i+1][l] <= cz_reg[i][l] + ARC;
                    end
                    else if (cy_reg[i][l] < 0)
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] - ys;
                        cy_reg[i+1][l] <= cy_reg[i][l] + xs;
                        cz_reg[i+1][l] <= cz_reg[i][l] - ARC;
                    end
                    else
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l];
                        cy_reg[i+1][l] <= cy_reg[i][l];
                        cz_reg[i+1][l] <= cz_reg[i][l];
                    end
                end
            end
        end
    end

    // round the angle to the output width
    logic signed [ZW-1:0] zr [0:2];
    for (genvar l = 0; l < 3; l++)
    begin : g_round
        if (SH > 0)
        begin : g_shift
            assign zr[l] = (cz_reg[NSTEP][l] + ZW'(64'sd1 <<< (SH - 1))) >>> SH;
        end
        else
        begin : g_plain
            assign zr[l] = cz_reg[NSTEP][l];
        end
    end

    // output register
    logic signed [ANGLE_WIDTH-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                          clamp_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cv_reg[NSTEP];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg  <= zr[0][ANGLE_WIDTH-1:0];
            yaw_reg   <= zr[2][ANGLE_WIDTH-1:0];
            clamp_reg <= cc_reg[NSTEP];
            if (cc_reg[NSTEP])
                pitch_reg <= cn_reg[NSTEP] ? -QUARTER : QUARTER;
            else
                pitch_reg <= zr[1][ANGLE_WIDTH-1:0];
        end
    end

    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign yaw_angle     = yaw_reg;
    assign pitch_clamped = clamp_reg;

    // checks
    a_clamp_quarter: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && pitch_clamped |-> pitch_angle == QUARTER || pitch_angle == -QUARTER)
        else $error("clamped pitch is not a quarter turn");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && !pitch_clamped |-> pitch_angle >= -QUARTER && pitch_angle <= QUARTER)
        else $error("pitch outside a quarter turn");

    a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vs_reg[SQ] && !ts_reg[SQ].clamp |-> sr_reg[SQ] <= NW'(ONE_D))
        else $error("pitch cosine above one");

    a_fold_positive: assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg[0] |-> !cx_reg[0][0][CW-1] && !cx_reg[0][1][CW-1] && !cx_reg[0][2][CW-1])
        else $error("folded x coordinate is negative");

endmodule

FILE: bench/tb_quaternion_to_euler.sv
// ============================================================================
// tb_quaternion_to_euler
// Self-checking bench for the quaternion to roll, pitch and yaw converter.
// A queue of quaternions feeds a driver with random idle bursts, a monitor
// compares every result beat against a bit-exact software prediction.
// ============================================================================
`timescale 1ns / 100ps

module tb_quaternion_to_euler;

    localparam int QW = qte_pkg::QUAT_WIDTH_DEF;
    localparam int AW = qte_pkg::ANGLE_WIDTH_DEF;
    localparam int FB = QW - 2;
    localparam int LATENCY = QW + 37;
    localparam int STALL_LIMIT = 5000;
    localparam int N_RANDOM = 1300;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] yaw;
        logic                 clamped;
    } euler_t;

    logic clk;
    logic rst_n;
    logic quat_valid;
    logic quat_stall;
    logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
    logic angle_valid;
    logic angle_stall;
    logic signed [AW-1:0] roll_angle, pitch_angle, yaw_angle;
    logic pitch_clamped;

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     stim_done = 0;
    bit     calm = 0;
    bit     hold_request = 0;
    bit     in_taken = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    int     hold_count = 0;

    quaternion_to_euler uut (
        .clk(clk), .rst_n(rst_n),
        .quat_valid(quat_valid), .quat_stall(quat_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .angle_valid(angle_valid), .angle_stall(angle_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic longint fshr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint clip_q(longint v);
        longint lim;
        lim = longint'(1) << (QW - 1);
        if (v > lim - 1)
            return lim - 1;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint pair_sum2(longint p1, longint p2);
        longint s;
        s = fshr(p1, 1) + fshr(p2, 1);
        return fshr(s + (longint'(1) << (FB - 3)), FB - 2);
    endfunction

    function automatic longint root_floor(longint n);
        longint res, bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // cordic vectoring to a binary angle
    function automatic logic [AW-1:0] vector_angle(longint y, longint x);
        longint ang, nx;
        int sh;
        ang = 0;
        sh = 32 - AW;
        if (x < 0)
        begin
            ang = (y >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
            x = -x;
            y = -y;
        end
        x = x * (longint'(1) << qte_pkg::PRESCALE_BITS);
        y = y * (longint'(1) << qte_pkg::PRESCALE_BITS);
        for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + fshr(y, i);
                y = y - fshr(x, i);
                ang = ang + longint'(qte_pkg::ARC_TABLE[i]);
                x = nx;
            end
            else if (y < 0)
            begin
                nx = x - fshr(y, i);
                y = y + fshr(x, i);
                ang = ang - longint'(qte_pkg::ARC_TABLE[i]);
                x = nx;
            end
        end
        if (sh > 0)
            ang = fshr(ang + (longint'(1) << (sh - 1)), sh);
        return ang[AW-1:0];
    endfunction

    function automatic euler_t euler_of(quat_t q);
        longint w, x, y, z, one, sinr, cosr, sinp, siny, cosy, quarter;
        euler_t e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        one = longint'(1) << FB;
        sinr = clip_q(pair_sum2(w * x, y * z));
        cosr = clip_q(one - pair_sum2(x * x, y * y));
        sinp = clip_q(pair_sum2(w * y, -(z * x)));
        siny = clip_q(pair_sum2(w * z, x * y));
        cosy = clip_q(one - pair_sum2(y * y, z * z));
        if (sinp >= one || sinp <= -one)
        begin
            quarter = longint'(1) << (AW - 2);
            e.clamped = 1'b1;
            e.pitch = (sinp > 0) ? quarter : -quarter;
        end
        else
        begin
            e.clamped = 1'b0;
            e.pitch = vector_angle(sinp, root_floor(one * one - sinp * sinp));
        end
        e.roll = vector_angle(sinr, cosr);
        e.yaw = vector_angle(siny, cosy);
        return e;
    endfunction

    function automatic quat_t mk(int w, int x, int y, int z);
        quat_t q;
        q.w = w; q.x = x; q.y = y; q.z = z;
        return q;
    endfunction

    // random quaternion near a scaled unit quaternion
    function automatic quat_t unit_ish();
        real a, b, c, d, n;
        quat_t q;
        a = $itor($urandom_range(0, 20000)) - 10000.0;
        b = $itor($urandom_range(0, 20000)) - 10000.0;
        c = $itor($urandom_range(0, 20000)) - 10000.0;
        d = $itor($urandom_range(0, 20000)) - 10000.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        q.w = $rtoi(a / n * 16384.0) + $urandom_range(0, 6) - 3;
        q.x = $rtoi(b / n * 16384.0) + $urandom_range(0, 6) - 3;
        q.y = $rtoi(c / n * 16384.0) + $urandom_range(0, 6) - 3;
        q.z = $rtoi(d / n * 16384.0) + $urandom_range(0, 6) - 3;
        return q;
    endfunction

    // stimulus
    initial
    begin
        quat_t q;
        int r;
        rst_n = 0;
        // extremes, identity, gimbal lock both signs, zero vector, pi wrap
        pending_quats.push_back(mk(16384, 0, 0, 0));
        pending_quats.push_back(mk(0, 0, 0, 0));
        pending_quats.push_back(mk(11585, 0, 11585, 0));
        pending_quats.push_back(mk(11585, 0, -11585, 0));
        pending_quats.push_back(mk(0, 16384, 0, 0));
        pending_quats.push_back(mk(0, 0, 0, 16384));
        pending_quats.push_back(mk(0, 0, 16384, 0));
        pending_quats.push_back(mk(32767, 32767, 32767, 32767));
        pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
        pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
        pending_quats.push_back(mk(32767, -32768, 32767, -32768));
        pending_quats.push_back(mk(11585, 11585, 0, 0));
        pending_quats.push_back(mk(-16384, 0, 0, 0));
        pending_quats.push_back(mk(8192, 8192, 8192, -8192));
        pending_quats.push_back(mk(8192, -8192, 8192, 8192));
        pending_quats.push_back(mk(1, -1, 1, -1));
        pending_quats.push_back(mk(0, 0, -32768, 0));
        pending_quats.push_back(mk(0, 1, 0, -1));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                q = unit_ish();
            else if (r < 8)
                q = quat_t'({32'd0, $urandom()});
            else
                q = quat_t'({$urandom(), $urandom()});
            pending_quats.push_back(q);
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    // input beat taken at the last rising edge
    always @(posedge clk)
        in_taken <= rst_n && quat_valid && !quat_stall;

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_valid <= 1'b0;
            quat_w <= '0; quat_x <= '0; quat_y <= '0; quat_z <= '0;
            send_gap <= 0;
        end
        else if (quat_valid && !in_taken)
        begin
            // hold the stalled beat
        end
        else if (send_gap > 0)
        begin
            quat_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_quats.size() > 0)
        begin
            if (!calm && $urandom_range(0, 15) == 0)
            begin
                quat_valid <= 1'b0;
                send_gap <= $urandom_range(1, 18) - 1;
            end
            else
            begin
                quat_t q;
                q = pending_quats.pop_front();
                quat_w <= q.w; quat_x <= q.x; quat_y <= q.y; quat_z <= q.z;
                quat_valid <= 1'b1;
            end
        end
        else
        begin
            quat_valid <= 1'b0;
            stim_done <= 1'b1;
        end
    end

    // calm tail and one long receiver hold-off
    always @(negedge clk)
    begin
        if (rst_n && pending_quats.size() < 150)
            calm <= 1'b1;
        if (rst_n && pending_quats.size() == 700 && hold_count == 0)
            hold_request <= 1'b1;
        else
            hold_request <= 1'b0;
    end

    // receiver stall
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_stall <= 1'b0;
            recv_gap <= 0;
            hold_count <= 0;
        end
        else if (hold_request)
        begin
            angle_stall <= 1'b1;
            hold_count <= 3 * LATENCY;
        end
        else if (hold_count > 1)
        begin
            angle_stall <= 1'b1;
            hold_count <= hold_count - 1;
        end
        else if (recv_gap > 0)
        begin
            angle_stall <= 1'b1;
            recv_gap <= recv_gap - 1;
            if (hold_count == 1)
                hold_count <= -1;
        end
        else if (!calm && $urandom_range(0, 15) == 0)
        begin
            angle_stall <= 1'b1;
            recv_gap <= $urandom_range(1, 18) - 1;
        end
        else
        begin
            angle_stall <= 1'b0;
            if (hold_count == 1)
                hold_count <= -1;
        end
    end

    // prediction on input beats, check on output beats
    always @(posedge clk)
    begin
        euler_t exp_e;
        quat_t q;
        if (rst_n)
        begin
            if (quat_valid && !quat_stall)
            begin
                q.w = quat_w; q.x = quat_x; q.y = quat_y; q.z = quat_z;
                expected_angles.push_back(euler_of(q));
            end
            if (angle_valid && !angle_stall)
            begin
                if (expected_angles.size() == 0)
                begin
                    $error("result beat with no expected result");
                    errors++;
                end
                else
                begin
                    exp_e = expected_angles.pop_front();
                    if (roll_angle !== exp_e.roll)
                    begin
                        $error("roll_angle expected %0d actual %0d", exp_e.roll, roll_angle);
                        errors++;
                    end
                    if (pitch_angle !== exp_e.pitch)
                    begin
                        $error("pitch_angle expected %0d actual %0d",
                               exp_e.pitch, pitch_angle);
                        errors++;
                    end
                    if (yaw_angle !== exp_e.yaw)
                    begin
                        $error("yaw_angle expected %0d actual %0d", exp_e.yaw, yaw_angle);
                        errors++;
                    end
                    if (pitch_clamped !== exp_e.clamped)
                    begin
                        $error("pitch_clamped expected %0d actual %0d",
                               exp_e.clamped, pitch_clamped);
                        errors++;
                    end
                end
            end
            if ((quat_valid && !quat_stall) || (angle_valid && !angle_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // end of run and watchdog
    initial
    begin
        @(posedge rst_n);
        while (!(stim_done && expected_angles.size() == 0) && idle_cycles < STALL_LIMIT)
            @(posedge clk);
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
        end
        else
        begin
            repeat (2 * LATENCY) @(posedge clk);
            if (errors == 0)
                $display("ALL CHECKS PASSED");
            else
                $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
